### rtl/dplt_pkg.sv
// Package for the demand paging LRU table unit.
// Holds the controller states, configuration register codes and reset values.
// No dependencies.
package dplt_pkg;

  // Controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_OWN_RD,
    ST_OWN_PT,
    ST_EVICT,
    ST_FILL,
    ST_DONE
  } state_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_VIRT_PAGE_COUNT = 2'd0,
    CFG_PHYS_PAGE_COUNT = 2'd1,
    CFG_PAGE_SHIFT      = 2'd2
  } cfg_idx_e;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned VCNT_W     = 11;
  localparam int unsigned PCNT_W     = 9;
  localparam int unsigned SHIFT_W    = 5;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned TOTAL_W    = 32;
  localparam int unsigned FRAME_O_W  = 8;
  localparam int unsigned STAMP_W    = 64;

  localparam logic [VCNT_W-1:0]  VCNT_RST  = 11'd1024;
  localparam logic [PCNT_W-1:0]  PCNT_RST  = 9'd256;
  localparam logic [SHIFT_W-1:0] SHIFT_RST = 5'd12;

endpackage

### rtl/dplt_if.sv
// Handshake channels of the demand paging LRU table unit.
// Request channel carries one access, response channel one result item.
// Uses widths from dplt_pkg.
interface dplt_req_if;
  logic                          valid;
  logic                          ready;
  logic [dplt_pkg::ADDR_W-1:0]   virt_address;
  logic                          is_write;

  modport source (output valid, output virt_address, output is_write, input ready);
  modport sink   (input valid, input virt_address, input is_write, output ready);
endinterface

interface dplt_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           hit;
  logic [dplt_pkg::FRAME_O_W-1:0] phys_frame;
  logic [1:0]                     disk_refs_now;
  logic                           range_error;
  logic [dplt_pkg::TOTAL_W-1:0]   fault_total;
  logic [dplt_pkg::TOTAL_W-1:0]   hit_total;
  logic [dplt_pkg::TOTAL_W-1:0]   disk_ref_total;

  modport source (output valid, output hit, output phys_frame, output disk_refs_now,
                  output range_error, output fault_total, output hit_total,
                  output disk_ref_total, input ready);
  modport sink   (input valid, input hit, input phys_frame, input disk_refs_now,
                  input range_error, input fault_total, input hit_total,
                  input disk_ref_total, output ready);
endinterface

### rtl/demand_paging_lru_table_unit.sv
// Demand paging page table with LRU frame replacement.
// Range errors go straight to the result, hits are looked up in the page table, and faults fill
// a free frame or else evict after a one-entry-per-cycle scan of the frame stamp memory.
// A result waits while the output register is full; a new item is taken while a result waits
// in the output register, but not while one waits to enter it.
// Reset: a clearing pass zeroes the page table and frame stamps; no item is accepted meanwhile,
// configuration writes are taken.
module demand_paging_lru_table_unit #(
  parameter int unsigned VIRT_PAGES  = 1024,
  parameter int unsigned PHYS_FRAMES = 256,
  parameter int unsigned AGE_BITS    = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dplt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dplt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  dplt_req_if.sink                        req_i,
  dplt_rsp_if.source                      rsp_o
);

  localparam int unsigned VW    = (VIRT_PAGES > 1) ? $clog2(VIRT_PAGES) : 1;
  localparam int unsigned FW    = (PHYS_FRAMES > 1) ? $clog2(PHYS_FRAMES) : 1;
  localparam int unsigned UW    = $clog2(PHYS_FRAMES + 1);
  localparam int unsigned CLR_N = (VIRT_PAGES > PHYS_FRAMES) ? VIRT_PAGES : PHYS_FRAMES;
  localparam int unsigned CW    = $clog2(CLR_N);
  localparam int unsigned PTW   = FW + 2;
  localparam int unsigned SW    = dplt_pkg::STAMP_W;
  localparam int unsigned TW    = dplt_pkg::TOTAL_W;
  localparam logic [SW-1:0] AGE_MAX = (SW'(1) << AGE_BITS) - SW'(1);

  dplt_pkg::state_e state_q, state_d;

  // Configuration registers
  logic [dplt_pkg::VCNT_W-1:0]  vcnt_q;
  logic [dplt_pkg::PCNT_W-1:0]  pcnt_q;
  logic [dplt_pkg::SHIFT_W-1:0] shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcnt_q  <= dplt_pkg::VCNT_RST;
      pcnt_q  <= dplt_pkg::PCNT_RST;
      shift_q <= dplt_pkg::SHIFT_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == dplt_pkg::CFG_VIRT_PAGE_COUNT) begin
        vcnt_q <= cfg_data_i[dplt_pkg::VCNT_W-1:0];
      end
      if (cfg_idx_i == dplt_pkg::CFG_PHYS_PAGE_COUNT) begin
        pcnt_q <= cfg_data_i[dplt_pkg::PCNT_W-1:0];
      end
      if (cfg_idx_i == dplt_pkg::CFG_PAGE_SHIFT) begin
        shift_q <= cfg_data_i[dplt_pkg::SHIFT_W-1:0];
      end
    end
  end

  // Effective limits
  logic [31:0] vlim, plim32;
  logic [UW-1:0] plim;
  always_comb begin
    vlim = (32'(vcnt_q) > 32'(VIRT_PAGES)) ? 32'(VIRT_PAGES) : 32'(vcnt_q);
    plim32 = 32'(pcnt_q);
    if (plim32 < 32'd1) begin
      plim32 = 32'd1;
    end
    if (plim32 > 32'(PHYS_FRAMES)) begin
      plim32 = 32'(PHYS_FRAMES);
    end
    plim = plim32[UW-1:0];
  end

  // Item and working registers
  logic [VW-1:0] vpn_q;
  logic          wr_q, rerr_q, hit_q;
  logic [FW-1:0] frame_q, scan_q, pidx_q, victim_q;
  logic          pv_q;
  logic [SW-1:0] best_q, now_q;
  logic [1:0]    refs_q;
  logic [UW-1:0] used_q;
  logic [CW-1:0] clr_q;
  logic [TW-1:0] faults_q, hits_q, drefs_q;

  // Memories: page table {resident, dirty, frame}, frame stamps, frame owners
  logic [PTW-1:0] pt_mem [VIRT_PAGES];
  logic [SW-1:0]  stamp_mem [PHYS_FRAMES];
  logic [VW-1:0]  owner_mem [PHYS_FRAMES];

  logic           pt_re, pt_we, st_re, st_we, ow_re, ow_we;
  logic [VW-1:0]  pt_raddr, pt_waddr;
  logic [PTW-1:0] pt_wdata, pt_rdata_q;
  logic [FW-1:0]  st_raddr, st_waddr, ow_raddr;
  logic [SW-1:0]  st_wdata, st_rdata_q;
  logic [VW-1:0]  ow_rdata_q;

  always_ff @(posedge clk_i) begin
    if (pt_we) begin
      pt_mem[pt_waddr] <= pt_wdata;
    end
    if (pt_re) begin
      pt_rdata_q <= pt_mem[pt_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      stamp_mem[st_waddr] <= st_wdata;
    end
    if (st_re) begin
      st_rdata_q <= stamp_mem[st_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ow_we) begin
      owner_mem[st_waddr] <= vpn_q;
    end
    if (ow_re) begin
      ow_rdata_q <= owner_mem[ow_raddr];
    end
  end

  // Decode the incoming address
  logic [31:0] vpn_in;
  logic        in_rerr, accept, rsp_free;
  assign vpn_in   = req_i.virt_address >> shift_q;
  assign in_rerr  = (vpn_in >= vlim);
  assign req_i.ready = (state_q == dplt_pkg::ST_IDLE);
  assign accept   = req_i.valid && req_i.ready;
  assign rsp_free = !rsp_o.valid || rsp_o.ready;

  // Page table fields of the last read
  logic          pt_res, pt_dirty;
  logic [FW-1:0] pt_frame;
  assign pt_res   = pt_rdata_q[PTW-1];
  assign pt_dirty = pt_rdata_q[PTW-2];
  assign pt_frame = pt_rdata_q[FW-1:0];

  logic scan_end;
  assign scan_end = ({{UW{1'b0}}, scan_q} == {{FW{1'b0}}, plim - UW'(1)});

  // Saturated age of the stamp under comparison
  logic [SW-1:0] diff, age;
  assign diff = now_q - st_rdata_q;
  assign age  = (diff > AGE_MAX) ? AGE_MAX : diff;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dplt_pkg::ST_CLEAR: begin
        if (clr_q == CW'(CLR_N - 1)) begin
          state_d = dplt_pkg::ST_IDLE;
        end
      end
      dplt_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = in_rerr ? dplt_pkg::ST_DONE : dplt_pkg::ST_LOOK;
        end
      end
      dplt_pkg::ST_LOOK: begin
        if (pt_res) begin
          state_d = dplt_pkg::ST_DONE;
        end else if (used_q < plim) begin
          state_d = dplt_pkg::ST_FILL;
        end else begin
          state_d = dplt_pkg::ST_SCAN;
        end
      end
      dplt_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_d = dplt_pkg::ST_SCAN_LAST;
        end
      end
      dplt_pkg::ST_SCAN_LAST: state_d = dplt_pkg::ST_OWN_RD;
      dplt_pkg::ST_OWN_RD:    state_d = dplt_pkg::ST_OWN_PT;
      dplt_pkg::ST_OWN_PT:    state_d = dplt_pkg::ST_EVICT;
      dplt_pkg::ST_EVICT:     state_d = dplt_pkg::ST_FILL;
      dplt_pkg::ST_FILL:      state_d = dplt_pkg::ST_DONE;
      dplt_pkg::ST_DONE: begin
        if (rsp_free) begin
          state_d = dplt_pkg::ST_IDLE;
        end
      end
      default: state_d = dplt_pkg::ST_CLEAR;
    endcase
  end

  // Memory controls
  always_comb begin
    pt_re    = 1'b0;
    pt_we    = 1'b0;
    st_re    = 1'b0;
    st_we    = 1'b0;
    ow_re    = 1'b0;
    ow_we    = 1'b0;
    pt_raddr = vpn_in[VW-1:0];
    pt_waddr = vpn_q;
    pt_wdata = '0;
    st_raddr = scan_q;
    st_waddr = frame_q;
    st_wdata = now_q + SW'(1);
    ow_raddr = victim_q;
    unique case (state_q)
      dplt_pkg::ST_CLEAR: begin
        pt_waddr = clr_q[VW-1:0];
        st_waddr = clr_q[FW-1:0];
        st_wdata = '0;
        pt_we    = (32'(clr_q) < 32'(VIRT_PAGES));
        st_we    = (32'(clr_q) < 32'(PHYS_FRAMES));
      end
      dplt_pkg::ST_IDLE: begin
        pt_re = accept && !in_rerr;
      end
      dplt_pkg::ST_LOOK: begin
        // Hit: mark dirty on write and renew the frame stamp
        st_waddr = pt_frame;
        st_we    = pt_res;
        pt_we    = pt_res && wr_q;
        pt_wdata = {1'b1, 1'b1, pt_frame};
      end
      dplt_pkg::ST_SCAN: begin
        st_re = 1'b1;
      end
      dplt_pkg::ST_OWN_RD: begin
        ow_re = 1'b1;
      end
      dplt_pkg::ST_OWN_PT: begin
        pt_raddr = ow_rdata_q;
        pt_re    = 1'b1;
      end
      dplt_pkg::ST_EVICT: begin
        // Drop the previous owner if it still maps the victim
        pt_waddr = ow_rdata_q;
        pt_wdata = '0;
        pt_we    = pt_res && (pt_frame == victim_q);
      end
      dplt_pkg::ST_FILL: begin
        pt_wdata = {1'b1, wr_q, frame_q};
        pt_we    = 1'b1;
        st_we    = 1'b1;
        ow_we    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Saturating total updates
  logic [TW:0] drefs_sum;
  assign drefs_sum = {1'b0, drefs_q} + (TW+1)'(refs_q);

  // Datapath and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= dplt_pkg::ST_CLEAR;
      clr_q    <= '0;
      used_q   <= '0;
      now_q    <= '0;
      faults_q <= '0;
      hits_q   <= '0;
      drefs_q  <= '0;
      pv_q     <= 1'b0;
      rsp_o.valid <= 1'b0;
    end else begin
      state_q <= state_d;
      // Raise valid when a result is loaded, drop it when the item is taken
      if (state_q == dplt_pkg::ST_DONE && rsp_free) begin
        rsp_o.valid <= 1'b1;
      end else if (rsp_o.valid && rsp_o.ready) begin
        rsp_o.valid <= 1'b0;
      end
      pv_q <= (state_q == dplt_pkg::ST_SCAN);
      unique case (state_q)
        dplt_pkg::ST_CLEAR: begin
          clr_q <= clr_q + CW'(1);
        end
        dplt_pkg::ST_IDLE: begin
          if (accept) begin
            vpn_q  <= vpn_in[VW-1:0];
            wr_q   <= req_i.is_write;
            rerr_q <= in_rerr;
            hit_q  <= 1'b0;
            refs_q <= 2'd0;
            frame_q <= '0;
          end
        end
        dplt_pkg::ST_LOOK: begin
          scan_q <= '0;
          if (pt_res) begin
            hit_q   <= 1'b1;
            frame_q <= pt_frame;
            now_q   <= now_q + SW'(1);
            if (hits_q != '1) begin
              hits_q <= hits_q + TW'(1);
            end
          end else begin
            refs_q <= 2'd1;
            if (faults_q != '1) begin
              faults_q <= faults_q + TW'(1);
            end
            if (used_q < plim) begin
              frame_q <= used_q[FW-1:0];
              used_q  <= used_q + UW'(1);
            end
          end
        end
        dplt_pkg::ST_SCAN: begin
          scan_q <= scan_q + FW'(1);
          pidx_q <= scan_q;
        end
        dplt_pkg::ST_EVICT: begin
          frame_q <= victim_q;
          if (pt_res && (pt_frame == victim_q) && pt_dirty) begin
            refs_q <= 2'd2;
          end
        end
        dplt_pkg::ST_FILL: begin
          now_q   <= now_q + SW'(1);
          drefs_q <= drefs_sum[TW] ? '1 : drefs_sum[TW-1:0];
        end
        default: begin
        end
      endcase
      // Track the first frame with the greatest age
      if (pv_q && ((pidx_q == '0) || (age > best_q))) begin
        best_q   <= age;
        victim_q <= pidx_q;
      end
    end
  end

  // Output register
  logic [31:0] frame32;
  assign frame32 = 32'(frame_q);

  always_ff @(posedge clk_i) begin
    if (state_q == dplt_pkg::ST_DONE && rsp_free) begin
      rsp_o.hit            <= hit_q && !rerr_q;
      rsp_o.phys_frame     <= rerr_q ? '0 : frame32[dplt_pkg::FRAME_O_W-1:0];
      rsp_o.disk_refs_now  <= rerr_q ? 2'd0 : refs_q;
      rsp_o.range_error    <= rerr_q;
      rsp_o.fault_total    <= faults_q;
      rsp_o.hit_total      <= hits_q;
      rsp_o.disk_ref_total <= drefs_q;
    end
  end

endmodule

### test/demand_paging_lru_table_unit_test.sv
// Self-checking bench for the demand paging LRU table unit.
// Depends on dplt_pkg, dplt_req_if and dplt_rsp_if from the rtl folder.
// A page table predictor checks every result item in order of arrival.
module demand_paging_lru_table_unit_test;

  localparam int unsigned TABLE_PAGES = 1024;
  localparam int unsigned TABLE_FRAMES = 256;
  localparam longint unsigned AGE_CEIL = 64'hFFFF_FFFF;
  localparam logic [dplt_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned LONG_HOLD = 300;

  // Idling modes of a phase
  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_SEND_IDLE,
    FLOW_RECV_STALL,
    FLOW_BOTH
  } flow_e;

  typedef struct packed {
    logic [dplt_pkg::ADDR_W-1:0] addr;
    logic                        wr;
  } access_t;

  typedef struct packed {
    logic                         hit;
    logic [7:0]                   frame;
    logic [1:0]                   refs;
    logic                         range_err;
    logic [dplt_pkg::TOTAL_W-1:0] faults;
    logic [dplt_pkg::TOTAL_W-1:0] hits;
    logic [dplt_pkg::TOTAL_W-1:0] disk_refs;
  } page_result_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [dplt_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [dplt_pkg::CFG_DATA_W-1:0] cfg_data_i;

  dplt_req_if req ();
  dplt_rsp_if rsp ();

  demand_paging_lru_table_unit uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .req_i     (req),
    .rsp_o     (rsp)
  );

  // Shadow configuration and page table
  logic [dplt_pkg::VCNT_W-1:0]  virt_count;
  logic [dplt_pkg::PCNT_W-1:0]  phys_count;
  logic [dplt_pkg::SHIFT_W-1:0] shift_amt;
  logic               page_resident [TABLE_PAGES];
  logic [7:0]         page_frame [TABLE_PAGES];
  logic               page_dirty [TABLE_PAGES];
  longint unsigned    frame_age [TABLE_FRAMES];
  int unsigned        frame_owner [TABLE_FRAMES];
  int unsigned        frames_filled;
  logic [dplt_pkg::TOTAL_W-1:0] fault_count, hit_count, disk_ref_count;

  access_t      pending_accesses[$];
  page_result_t expected_results[$];
  flow_e        flow;
  int unsigned  mismatches;
  int unsigned  hold_ticket;
  logic         req_taken;

  function automatic logic [dplt_pkg::TOTAL_W-1:0] bump(logic [dplt_pkg::TOTAL_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Resolve one access against the shadow page table
  function automatic page_result_t resolve_access(logic [dplt_pkg::ADDR_W-1:0] addr, logic wr);
    page_result_t res;
    int unsigned vlim, plim, vpn, victim, owner;
    longint unsigned oldest;
    res = '0;
    vlim = (virt_count > TABLE_PAGES) ? TABLE_PAGES : virt_count;
    plim = (phys_count == 0) ? 1 : ((phys_count > TABLE_FRAMES) ? TABLE_FRAMES : phys_count);
    vpn = addr >> shift_amt;
    if (vpn >= vlim) begin
      res.range_err = 1'b1;
    end else if (page_resident[vpn]) begin
      res.hit = 1'b1;
      res.frame = page_frame[vpn];
      hit_count = bump(hit_count);
      if (wr) page_dirty[vpn] = 1'b1;
    end else begin
      fault_count = bump(fault_count);
      res.refs = 2'd1;
      if (frames_filled < plim) begin
        res.frame = frames_filled[7:0];
        frames_filled++;
      end else begin
        // pick the first frame with the greatest age
        victim = 0;
        oldest = frame_age[0];
        for (int f = 1; f < plim; f++)
          if (frame_age[f] > oldest) begin
            oldest = frame_age[f];
            victim = f;
          end
        owner = frame_owner[victim];
        if (page_resident[owner] && page_frame[owner] == victim[7:0]) begin
          if (page_dirty[owner]) res.refs = 2'd2;
          page_resident[owner] = 1'b0;
          page_dirty[owner] = 1'b0;
        end
        res.frame = victim[7:0];
      end
      page_frame[vpn] = res.frame;
      page_resident[vpn] = 1'b1;
      page_dirty[vpn] = wr;
      frame_owner[res.frame] = vpn;
      disk_ref_count = bump(disk_ref_count);
      if (res.refs == 2'd2) disk_ref_count = bump(disk_ref_count);
    end
    if (!res.range_err) begin
      for (int f = 0; f < TABLE_FRAMES; f++)
        if (frame_age[f] < AGE_CEIL) frame_age[f]++;
      frame_age[res.frame] = 0;
    end
    res.faults = fault_count;
    res.hits = hit_count;
    res.disk_refs = disk_ref_count;
    return res;
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watch the input handshake and predict, check result items, run the watchdog
  int unsigned quiet_cycles;
  initial quiet_cycles = 0;
  always @(posedge clk_i) begin
    page_result_t want, got;
    req_taken = req.valid && req.ready && rst_ni;
    if (req_taken) expected_results.push_back(resolve_access(req.virt_address, req.is_write));
    if (rsp.valid && rsp.ready && rst_ni) begin
      got = '{rsp.hit, rsp.phys_frame, rsp.disk_refs_now, rsp.range_error,
              rsp.fault_total, rsp.hit_total, rsp.disk_ref_total};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %p", got);
      end else begin
        want = expected_results.pop_front();
        if (got.hit !== want.hit || got.frame !== want.frame || got.refs !== want.refs ||
            got.range_err !== want.range_err || got.faults !== want.faults ||
            got.hits !== want.hits || got.disk_refs !== want.disk_refs) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
    if (req_taken || (rsp.valid && rsp.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog expired with %0d items outstanding", expected_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer access items; hold an item until it is taken
  always @(negedge clk_i) begin
    access_t nxt;
    if (rst_ni && (!req.valid || req_taken)) begin
      if (pending_accesses.size() > 0 &&
          !((flow == FLOW_SEND_IDLE && $urandom_range(99) < 86) ||
            (flow == FLOW_BOTH && $urandom_range(99) < 8))) begin
        nxt = pending_accesses.pop_front();
        req.virt_address <= nxt.addr;
        req.is_write <= nxt.wr;
        req.valid <= 1'b1;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // Drive the result ready, with random stalls and a long hold-off on request
  int unsigned hold_seen, hold_left;
  initial begin
    hold_seen = 0;
    hold_left = 0;
  end
  always @(negedge clk_i) begin
    if (hold_ticket != hold_seen) begin
      hold_seen = hold_ticket;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp.ready <= 1'b0;
    end else if (flow == FLOW_RECV_STALL) begin
      rsp.ready <= ($urandom_range(99) >= 86);
    end else if (flow == FLOW_BOTH) begin
      rsp.ready <= ($urandom_range(99) >= 8);
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // Write one register and mirror it in the shadow copy
  task automatic write_reg(logic [dplt_pkg::CFG_IDX_W-1:0] idx, int unsigned value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value[dplt_pkg::CFG_DATA_W-1:0];
    case (idx)
      dplt_pkg::CFG_VIRT_PAGE_COUNT: virt_count = value[dplt_pkg::VCNT_W-1:0];
      dplt_pkg::CFG_PHYS_PAGE_COUNT: phys_count = value[dplt_pkg::PCNT_W-1:0];
      dplt_pkg::CFG_PAGE_SHIFT:      shift_amt = value[dplt_pkg::SHIFT_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_accesses.size() > 0 || expected_results.size() > 0 || req.valid)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_layout(int unsigned vcnt, int unsigned pcnt, int unsigned sh);
    drain();
    write_reg(dplt_pkg::CFG_VIRT_PAGE_COUNT, vcnt);
    write_reg(dplt_pkg::CFG_PHYS_PAGE_COUNT, pcnt);
    write_reg(dplt_pkg::CFG_PAGE_SHIFT, sh);
  endtask

  task automatic queue_access(int unsigned vpn, int unsigned low, logic wr);
    access_t a;
    a.addr = (32'(vpn) << shift_amt) | (32'(low) & ((32'h1 << shift_amt) - 1));
    a.wr = wr;
    pending_accesses.push_back(a);
  endtask

  // Mostly accesses in a small working set, some noise across the whole space
  task automatic queue_random(int unsigned count, int unsigned span);
    access_t a;
    repeat (count) begin
      if ($urandom_range(99) < 85) begin
        queue_access($urandom_range(span), $urandom, 1'($urandom_range(1)));
      end else begin
        a.addr = $urandom;
        a.wr = 1'($urandom_range(1));
        pending_accesses.push_back(a);
      end
    end
  endtask

  initial begin
    virt_count = dplt_pkg::VCNT_RST;
    phys_count = dplt_pkg::PCNT_RST;
    shift_amt = dplt_pkg::SHIFT_RST;
    for (int p = 0; p < TABLE_PAGES; p++) begin
      page_resident[p] = 1'b0;
      page_dirty[p] = 1'b0;
      page_frame[p] = '0;
    end
    for (int f = 0; f < TABLE_FRAMES; f++) begin
      frame_age[f] = 0;
      frame_owner[f] = 0;
    end
    frames_filled = 0;
    fault_count = '0;
    hit_count = '0;
    disk_ref_count = '0;
    mismatches = 0;
    hold_ticket = 0;
    req_taken = 1'b0;
    flow = FLOW_FREE;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    req.valid = 1'b0;
    req.virt_address = '0;
    req.is_write = 1'b0;
    rsp.ready = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset layout: miss, out of range, write hit, top page, just past the top, write hit on top page
    queue_access(0, 0, 1'b0);
    pending_accesses.push_back('{32'hFFFF_FFFF, 1'b1});
    queue_access(0, 32'hFFF, 1'b1);
    queue_access(1023, 5, 1'b0);
    queue_access(1024, 0, 1'b1);
    queue_access(1023, 0, 1'b1);

    // One frame: dirty and clean evictions; unused register index is ignored
    set_layout(4, 1, 0);
    write_reg(CFG_SPARE_IDX, 11'h7FF);
    queue_access(0, 0, 1'b1);
    queue_access(1, 0, 1'b0);
    queue_access(1, 0, 1'b1);
    queue_access(2, 0, 1'b0);
    queue_access(4, 0, 1'b0);
    queue_access(3, 0, 1'b1);

    // Zero page count and zero frame count
    set_layout(0, 0, 31);
    queue_access(0, 0, 1'b0);
    pending_accesses.push_back('{32'h8000_0000, 1'b1});
    set_layout(2047, 0, 31);
    pending_accesses.push_back('{32'h8000_0000, 1'b1});
    queue_access(0, 32'h7FFF_FFFF, 1'b0);
    queue_access(1, 1, 1'b0);

    // Random phases across layouts and flow modes
    set_layout(16, 4, 4);
    queue_random(100, 17);
    set_layout(2047, 3, 12);
    flow = FLOW_SEND_IDLE;
    queue_random(100, 9);
    set_layout(64, 511, 0);
    flow = FLOW_RECV_STALL;
    queue_random(100, 64);
    set_layout(8, 2, 31);
    flow = FLOW_BOTH;
    queue_random(100, 1);
    set_layout(1024, 256, 20);
    flow = FLOW_FREE;
    queue_random(100, 1023);
    set_layout(300, 8, 9);
    hold_ticket++;
    queue_random(100, 20);
    set_layout(1024, 6, 12);
    flow = FLOW_BOTH;
    queue_random(100, 12);

    drain();
    repeat (300) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
